// ===== rtl/core/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg: shared types and constants for the ready queue selector
// Record layout, action and status codes, FSM states and scan control.
// ----------------------------------------------------------------------------
`default_nettype none

package rqs_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Action codes
   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_OLDEST = 3'd1;
   localparam logic [2:0] ACT_PRIO   = 3'd2;
   localparam logic [2:0] ACT_BURST  = 3'd3;
   localparam logic [2:0] ACT_DELETE = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   // One task record
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [2:0]  cls;
   } rqs_rec_type;

   // Control FSM
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMPACT,
      S_FINISH
   } rqs_state_type;

   // Per-cycle scan control into the selector
   typedef struct packed {
      logic             scan_en;
      logic             first;
      logic             in_range;
      logic [IDX_W-1:0] step;
   } rqs_scan_ctl_type;

   // Selector result
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } rqs_hit_type;

endpackage : rqs_pkg

`default_nettype wire

// ===== rtl/core/rqs_req_if.sv =====
// ----------------------------------------------------------------------------
// rqs_req_if: request channel of the ready queue selector
// Valid/ready handshake carrying one action and its task record.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] task_id;
   logic [15:0] burst_length;
   logic [7:0]  task_priority;
   logic [2:0]  task_class;

   modport source (
      output valid, action, task_id, burst_length, task_priority, task_class,
      input  ready
   );

   modport sink (
      input  valid, action, task_id, burst_length, task_priority, task_class,
      output ready
   );
endinterface : rqs_req_if

`default_nettype wire

// ===== rtl/core/rqs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rqs_rsp_if: response channel of the ready queue selector
// Valid/ready handshake carrying status, selected record and queue count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] found_id;
   logic [15:0] found_burst;
   logic [7:0]  found_priority;
   logic [2:0]  found_class;
   logic [4:0]  entry_count;
   logic        is_empty;

   modport source (
      output valid, status, found_id, found_burst, found_priority, found_class,
             entry_count, is_empty,
      input  ready
   );

   modport sink (
      input  valid, status, found_id, found_burst, found_priority, found_class,
             entry_count, is_empty,
      output ready
   );
endinterface : rqs_rsp_if

`default_nettype wire

// ===== rtl/core/rqs_cell.sv =====
// ----------------------------------------------------------------------------
// rqs_cell: one slot of the record chain
// Holds a record; takes its neighbor's record on shift or a new one on load.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_cell
   import rqs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        shift,
   input  wire logic        load,
   input  wire rqs_rec_type nbr_rec,
   input  wire rqs_rec_type load_rec,
   output rqs_rec_type      rec
);

   rqs_rec_type rec_ff;
   rqs_rec_type rec_in;

   // load wins over shift; they never coincide in practice
   always_comb begin
      if (load) begin
         rec_in = load_rec;
      end else if (shift) begin
         rec_in = nbr_rec;
      end else begin
         rec_in = rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule : rqs_cell

`default_nettype wire

// ===== rtl/core/rqs_select.sv =====
// ----------------------------------------------------------------------------
// rqs_select: scan selector at the head of the chain
// Watches records pass the head one per cycle and keeps the chosen one.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_select
   import rqs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rqs_scan_ctl_type ctl,
   input  wire logic [2:0]       action,
   input  wire logic [15:0]      target_id,
   input  wire rqs_rec_type      head_rec,
   output rqs_rec_type           best_rec,
   output rqs_hit_type           hit
);

   rqs_rec_type      best_ff;
   logic             found_ff;
   logic [IDX_W-1:0] index_ff;
   logic             take;

   // Strict less-than keeps ties on the earliest entry
   always_comb begin
      case (action)
         ACT_OLDEST: take = ctl.first;
         ACT_PRIO:   take = ctl.first || (head_rec.prio < best_ff.prio);
         ACT_BURST:  take = ctl.first || (head_rec.burst < best_ff.burst);
         ACT_DELETE: take = (ctl.first || !found_ff) && (head_rec.id == target_id);
         default:    take = 1'b0;
      endcase
      take = take && ctl.scan_en && ctl.in_range;
   end

   // Captured record and index
   always_ff @(posedge clock) begin
      if (take) begin
         best_ff  <= head_rec;
         index_ff <= ctl.step;
      end
   end

   // Hit flag, cleared at the start of each scan
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end else if (ctl.scan_en && ctl.first) begin
         found_ff <= 1'b0;
      end
   end

   assign best_rec  = best_ff;
   assign hit.found = found_ff;
   assign hit.index = index_ff;

endmodule : rqs_select

`default_nettype wire

// ===== rtl/core/ready_queue_select.sv =====
// ----------------------------------------------------------------------------
// ready_queue_select: ordered ready queue with oldest / priority / burst pick
// Chain of record cells that rotates past a selector at its head.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one action per transaction (append, oldest, lowest
//   priority value, smallest burst, delete by id) with a task record.
//   rsp_ch returns exactly one transaction per request: status, the
//   selected or deleted record, and the count and empty flag afterwards.
//   Append, unused codes and empty-queue actions go from idle straight
//   to the finish state, where the response is registered.
//   Queries and deletes rotate the chain once past the selector in the
//   scan state; a delete then passes through the compact state.
//   One request is in flight at a time; req_ch.ready is high only while
//   the controller is idle. The output register lets the next request be
//   accepted while a response still waits; if the receiver stalls, the
//   following request holds in its finish state until the register frees.
//   Reset (synchronous, active high) empties the queue and drops any
//   pending response; record contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_select
   import rqs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rqs_req_if.sink   req_ch,
   rqs_rsp_if.source rsp_ch
);

   rqs_state_type    state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       act_ff;
   rqs_rec_type      req_rec_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff;
   rqs_rec_type      out_rec_ff;
   logic [CNT_W-1:0] out_count_ff;

   logic             accept, out_free, finish_go;
   logic             in_idle, in_scan, in_compact, in_finish;
   logic             last_step;
   logic             is_full;
   logic [1:0]       fin_status;
   rqs_rec_type      fin_rec;
   logic [CNT_W-1:0] fin_count;
   logic             do_append;

   rqs_rec_type      cell_q [QUEUE_DEPTH];
   rqs_rec_type      best_rec;
   rqs_hit_type      hit;
   rqs_scan_ctl_type scan_ctl;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ch.ready;
   assign last_step = (step_ff == IDX_W'(QUEUE_DEPTH - 1));
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.action) inside
                  ACT_OLDEST, ACT_PRIO, ACT_BURST, ACT_DELETE:
                     state_in = (count_ff != '0) ? S_SCAN : S_FINISH;
                  default:
                     state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            if (last_step) begin
               state_in = (act_ff == ACT_DELETE) ? S_COMPACT : S_FINISH;
            end
         end
         S_COMPACT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State decode outputs
   always_comb begin
      in_idle    = 1'b0;
      in_scan    = 1'b0;
      in_compact = 1'b0;
      in_finish  = 1'b0;
      unique case (state_ff)
         S_IDLE:    in_idle    = 1'b1;
         S_SCAN:    in_scan    = 1'b1;
         S_COMPACT: in_compact = 1'b1;
         S_FINISH:  in_finish  = 1'b1;
         default:   in_idle    = 1'b0;
      endcase
   end

   assign req_ch.ready = in_idle;
   assign finish_go    = in_finish && out_free;

   // Scan step counter: head cell holds entry step_ff during the scan
   assign step_in = in_scan ? step_ff + IDX_W'(1) : '0;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff           <= req_ch.action;
         req_rec_ff.id    <= req_ch.task_id;
         req_rec_ff.burst <= req_ch.burst_length;
         req_rec_ff.prio  <= req_ch.task_priority;
         req_rec_ff.cls   <= req_ch.task_class;
      end
   end

   // Result of the finished action
   always_comb begin
      fin_status = ST_OK;
      fin_rec    = '0;
      fin_count  = count_ff;
      do_append  = 1'b0;
      case (act_ff)
         ACT_APPEND: begin
            if (is_full) begin
               fin_status = ST_FULL;
            end else begin
               do_append = 1'b1;
               fin_count = count_ff + CNT_W'(1);
            end
         end
         ACT_OLDEST, ACT_PRIO, ACT_BURST: begin
            if (count_ff == '0) begin
               fin_status = ST_EMPTY;
            end else begin
               fin_rec = best_rec;
            end
         end
         ACT_DELETE: begin
            if ((count_ff != '0) && hit.found) begin
               fin_rec   = best_rec;
               fin_count = count_ff - CNT_W'(1);
            end else begin
               fin_status = ST_MISSING;
            end
         end
         default: begin
            fin_status = ST_OK;
         end
      endcase
   end

   assign count_in = finish_go ? fin_count : count_ff;

   // Response valid: set on finish, cleared when taken
   always_comb begin
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Response payload register
   always_ff @(posedge clock) begin
      if (finish_go) begin
         status_ff    <= fin_status;
         out_rec_ff   <= fin_rec;
         out_count_ff <= fin_count;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.found_id       = out_rec_ff.id;
   assign rsp_ch.found_burst    = out_rec_ff.burst;
   assign rsp_ch.found_priority = out_rec_ff.prio;
   assign rsp_ch.found_class    = out_rec_ff.cls;
   assign rsp_ch.entry_count    = 5'(out_count_ff);
   assign rsp_ch.is_empty       = (out_count_ff == '0);

   // Record chain: rotates during a scan, closes the gap after a delete hit
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic cell_shift;
      logic cell_load;

      assign cell_shift = in_scan ||
                          (in_compact && hit.found && (IDX_W'(k) >= hit.index));
      assign cell_load  = finish_go && do_append && (CNT_W'(k) == count_ff);

      rqs_cell u_cell (
         .clock    (clock),
         .shift    (cell_shift),
         .load     (cell_load),
         .nbr_rec  (cell_q[(k + 1) % QUEUE_DEPTH]),
         .load_rec (req_rec_ff),
         .rec      (cell_q[k])
      );
   end

   // Selector at the head of the chain
   assign scan_ctl.scan_en  = in_scan;
   assign scan_ctl.first    = (step_ff == '0);
   assign scan_ctl.in_range = (CNT_W'(step_ff) < count_ff);
   assign scan_ctl.step     = step_ff;

   rqs_select u_select (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .action    (act_ff),
      .target_id (req_rec_ff.id),
      .head_rec  (cell_q[0]),
      .best_rec  (best_rec),
      .hit       (hit)
   );

endmodule : ready_queue_select

`default_nettype wire
